// ----- hw/rtl/lsas_pkg.sv -----
// Shared types and constants for the LED strip animation sequencer.
`timescale 1ns / 1ps
package lsas_pkg;

  localparam int NUM_LEDS    = 18;
  localparam int PHASE_COUNT = 6;
  localparam int LED_LAST    = NUM_LEDS - 1;
  localparam int FILL_HALF   = NUM_LEDS / 2;
  localparam int STEP_W      = 5;
  localparam int BRIGHT_W    = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [NUM_LEDS-1:0] LED_ALL     = {NUM_LEDS{1'b1}};
  localparam logic [BRIGHT_W-1:0] FULL_BRIGHT = {BRIGHT_W{1'b1}};

  localparam logic [BRIGHT_W-1:0] BREATH_STEP_RST = 16'd4000;
  localparam logic [BRIGHT_W-1:0] BREATH_HIGH_RST = 16'd50000;
  localparam logic [BRIGHT_W-1:0] BREATH_LOW_RST  = 16'd5000;
  localparam logic [BRIGHT_W-1:0] HOLD_BRIGHT_RST = 16'd50000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BREATH_STEP = 2'd0,
    CFG_BREATH_HIGH = 2'd1,
    CFG_BREATH_LOW  = 2'd2,
    CFG_HOLD_BRIGHT = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_AUTO       = 3'd0,
    MODE_HOLD       = 3'd1,
    MODE_SWEEP_L    = 3'd2,
    MODE_SWEEP_R    = 3'd3,
    MODE_FLASH      = 3'd4,
    MODE_FILL_CTR   = 3'd5,
    MODE_FILL_EDGE  = 3'd6,
    MODE_ALL_ON     = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    SP_LEFT        = 3'd0,
    SP_RIGHT       = 3'd1,
    SP_BREATH_UP   = 3'd2,
    SP_BREATH_DOWN = 3'd3,
    SP_DARK        = 3'd4,
    SP_FULL        = 3'd5
  } sub_phase_t;

  typedef struct packed {
    logic [STEP_W-1:0]   step;
    logic [NUM_LEDS-1:0] leds;
  } pat_t;

  typedef struct packed {
    logic [NUM_LEDS-1:0] led_mask;
    logic                bright_write;
    logic [BRIGHT_W-1:0] bright_value;
  } res_t;

endpackage

// ----- hw/rtl/led_strip_animation_sequencer.sv -----
// LED strip animation sequencer: one tick per beat, one LED/brightness result per phase cycle.
// Results are registered: out_r, or the skid entry when out_r is stalled, takes each result.
// Throughput: one tick per clock while in_stall is low; a result on every PHASE_CNT-th tick.
// A two-entry output buffer (result register plus skid) takes stalls; in_stall rises only
// when both entries hold results.
// Reset (rst_n low, synchronous): state cleared, LEDs off, config registers to defaults.
`timescale 1ns / 1ps
module led_strip_animation_sequencer
  import lsas_pkg::*;
#(
  parameter int PHASE_CNT = PHASE_COUNT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BRIGHT_W-1:0]  cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_mode_valid,
  input  logic [2:0]           in_mode_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [NUM_LEDS-1:0]  out_led_mask,
  output logic                 out_bright_write,
  output logic [BRIGHT_W-1:0]  out_bright_value
);

  localparam int PH_W = $clog2(PHASE_CNT + 1);
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(PHASE_CNT);
  localparam logic [PH_W-1:0] PH_ONE  = PH_W'(1);

  localparam logic [STEP_W-1:0] S_LAST  = STEP_W'(LED_LAST);
  localparam logic [STEP_W-1:0] S_CLR   = STEP_W'(NUM_LEDS);
  localparam logic [STEP_W-1:0] F_LAST  = STEP_W'(FILL_HALF - 1);
  localparam logic [STEP_W-1:0] F_CLR   = STEP_W'(FILL_HALF);
  localparam logic [STEP_W-1:0] FL_END  = STEP_W'(4);

  // config
  logic [BRIGHT_W-1:0] breath_step_r, breath_high_r, breath_low_r, hold_bright_r;

  // state
  logic [PH_W-1:0]     phase_r, phase_nxt;
  mode_t               cur_mode_r, prev_mode_r;
  logic [STEP_W-1:0]   step_r, step_nxt;
  sub_phase_t          sub_r, sub_nxt;
  logic                mark_r, mark_nxt;
  logic [BRIGHT_W-1:0] level_r, level_nxt;
  logic [NUM_LEDS-1:0] leds_r, leds_nxt;

  // output buffer
  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r, res_nxt;

  logic acc, step_tick, out_take;

  function automatic logic [NUM_LEDS-1:0] bit_at(input logic [STEP_W-1:0] idx);
    bit_at = NUM_LEDS'(1) << idx;
  endfunction

  function automatic pat_t sweep_f(input logic [STEP_W-1:0] sc,
                                   input logic [NUM_LEDS-1:0] leds,
                                   input logic rightward);
    pat_t              p;
    logic [STEP_W:0]   inc;
    p.leds = leds;
    if (sc <= S_LAST) begin
      p.leds = leds | bit_at(rightward ? (S_LAST - sc) : sc);
    end else if (sc == S_CLR) begin
      p.leds = '0;
    end
    inc = {1'b0, sc} + 1'b1;
    p.step = (inc > {1'b0, S_CLR}) ? '0 : inc[STEP_W-1:0];
    sweep_f = p;
  endfunction

  function automatic pat_t fill_f(input logic [STEP_W-1:0] sc,
                                  input logic [NUM_LEDS-1:0] leds,
                                  input logic from_edges);
    pat_t            p;
    logic [STEP_W:0] inc;
    p.leds = leds;
    if (sc <= F_LAST) begin
      if (from_edges) begin
        p.leds = leds | bit_at(S_LAST - sc) | bit_at(sc);
      end else begin
        p.leds = leds | bit_at(F_LAST - sc) | bit_at(F_CLR + sc);
      end
    end else if (sc == F_CLR) begin
      p.leds = '0;
    end
    inc = {1'b0, sc} + 1'b1;
    p.step = (inc > {1'b0, F_CLR}) ? '0 : inc[STEP_W-1:0];
    fill_f = p;
  endfunction

  assign in_stall  = skid_valid_r;
  assign acc       = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign phase_nxt = (phase_r == PH_LAST) ? PH_ONE : phase_r + PH_ONE;
  assign step_tick = (phase_nxt == PH_ONE);

  // pattern step
  always_comb begin
    pat_t                p;
    logic [STEP_W-1:0]   sc;
    logic [NUM_LEDS-1:0] led;
    logic                wr;
    logic [BRIGHT_W-1:0] wv;
    sc        = step_r;
    led       = leds_r;
    sub_nxt   = sub_r;
    mark_nxt  = mark_r;
    level_nxt = level_r;
    wr        = 1'b0;
    wv        = '0;
    p         = '0;
    if (cur_mode_r != prev_mode_r) begin
      sc      = '0;
      sub_nxt = SP_LEFT;
      led     = '0;
    end
    // sweep, flash and fill modes leave the breathing all-on state first
    if (cur_mode_r == MODE_SWEEP_L || cur_mode_r == MODE_SWEEP_R ||
        cur_mode_r == MODE_FLASH || cur_mode_r == MODE_FILL_CTR ||
        cur_mode_r == MODE_FILL_EDGE) begin
      if (mark_r) begin
        led      = '0;
        mark_nxt = 1'b0;
        wr       = 1'b1;
        wv       = hold_bright_r;
      end
    end
    case (cur_mode_r)
      MODE_AUTO: begin
        case (sub_nxt)
          SP_LEFT, SP_RIGHT: begin
            p   = sweep_f(sc, led, sub_nxt == SP_RIGHT);
            sc  = p.step;
            led = p.leds;
            if (p.step == '0) begin
              if (sub_nxt == SP_RIGHT) begin
                sub_nxt = SP_BREATH_UP;
                wr      = 1'b1;
                wv      = '0;
              end else begin
                sub_nxt = SP_RIGHT;
              end
            end
          end
          SP_BREATH_UP: begin
            if (!mark_r) begin
              led      = LED_ALL;
              mark_nxt = 1'b1;
            end
            level_nxt = level_r + breath_step_r;
            wr        = 1'b1;
            wv        = level_nxt;
            if (level_nxt >= breath_high_r) sub_nxt = SP_BREATH_DOWN;
          end
          SP_BREATH_DOWN: begin
            level_nxt = level_r - breath_step_r;
            wr        = 1'b1;
            wv        = level_nxt;
            if (level_nxt <= breath_low_r) sub_nxt = SP_DARK;
          end
          SP_DARK: begin
            if (mark_r) begin
              led      = '0;
              mark_nxt = 1'b0;
            end
            sub_nxt = SP_FULL;
          end
          SP_FULL: begin
            wr = 1'b1;
            wv = FULL_BRIGHT;
          end
          default: ;
        endcase
      end
      MODE_SWEEP_L, MODE_SWEEP_R: begin
        p   = sweep_f(sc, led, cur_mode_r == MODE_SWEEP_R);
        sc  = p.step;
        led = p.leds;
      end
      MODE_FLASH: begin
        if (sc == STEP_W'(1) || sc == STEP_W'(3)) begin
          led = LED_ALL;
        end else if (sc == STEP_W'(2) || sc == FL_END) begin
          led = '0;
        end
        if (sc <= FL_END) sc = sc + 1'b1;
      end
      MODE_FILL_CTR, MODE_FILL_EDGE: begin
        p   = fill_f(sc, led, cur_mode_r == MODE_FILL_EDGE);
        sc  = p.step;
        led = p.leds;
      end
      MODE_ALL_ON: led = LED_ALL;
      default: ;  // hold keeps the LEDs
    endcase
    step_nxt             = sc;
    leds_nxt             = led;
    res_nxt.led_mask     = led;
    res_nxt.bright_write = wr;
    res_nxt.bright_value = wv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      breath_step_r <= BREATH_STEP_RST;
      breath_high_r <= BREATH_HIGH_RST;
      breath_low_r  <= BREATH_LOW_RST;
      hold_bright_r <= HOLD_BRIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BREATH_STEP: breath_step_r <= cfg_wdata;
        CFG_BREATH_HIGH: breath_high_r <= cfg_wdata;
        CFG_BREATH_LOW:  breath_low_r  <= cfg_wdata;
        CFG_HOLD_BRIGHT: hold_bright_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      cur_mode_r  <= MODE_AUTO;
      prev_mode_r <= MODE_AUTO;
      step_r      <= '0;
      sub_r       <= SP_LEFT;
      mark_r      <= 1'b0;
      level_r     <= '0;
      leds_r      <= '0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      if (step_tick) begin
        step_r  <= step_nxt;
        sub_r   <= sub_nxt;
        mark_r  <= mark_nxt;
        level_r <= level_nxt;
        leds_r  <= leds_nxt;
      end
      // mode update uses the mode the step just ran with
      if (in_mode_valid) begin
        prev_mode_r <= cur_mode_r;
        cur_mode_r  <= mode_t'(in_mode_in);
      end
    end
  end

  // result register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (acc && step_tick) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) out_r <= skid_r;
    end else if (acc && step_tick) begin
      if (!out_valid_r || out_take) begin
        out_r <= res_nxt;
      end else begin
        skid_r <= res_nxt;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_led_mask     = out_r.led_mask;
  assign out_bright_write = out_r.bright_write;
  assign out_bright_value = out_r.bright_value;

endmodule
